/* hw/rtl/bbc_pkg.sv */
// Shared constants, register map and types for the Butterworth biquad cascade.
`default_nettype none

package bbc_pkg;

   // Structural constants
   localparam int SECTIONS    = 2;
   localparam int SAMPLE_BITS = 24;

   // Fixed field widths
   localparam int IN_BITS   = 24;
   localparam int OUT_BITS  = 24;
   localparam int COEF_BITS = 24;
   localparam int COEF_FRAC = 21;

   // Derived datapath widths
   localparam int SECT_BITS = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS  = PROD_BITS + 4;
   localparam int RND_BITS  = ACC_BITS - COEF_FRAC;
   localparam int WIDE_BITS = ((SAMPLE_BITS > IN_BITS) ? SAMPLE_BITS : IN_BITS) + 1;

   // Multiply-accumulate steps of one section
   localparam int STEP_BITS = 3;
   localparam logic [STEP_BITS-1:0] OP_X0 = 3'd0;  // a0 * x
   localparam logic [STEP_BITS-1:0] OP_X1 = 3'd1;  // a1 * x1, a1 = 2*a0, negated in high-pass mode
   localparam logic [STEP_BITS-1:0] OP_X2 = 3'd2;  // a2 * x2, a2 = a0
   localparam logic [STEP_BITS-1:0] OP_Y1 = 3'd3;  // b1 * y1
   localparam logic [STEP_BITS-1:0] OP_Y2 = 3'd4;  // b2 * y2

   // Register map
   localparam int REG_COUNT = 7;
   localparam int REG_BITS  = $clog2(REG_COUNT);
   localparam int ADDR_BITS = REG_BITS + 2;
   localparam int DATA_BITS = 32;
   localparam logic [REG_BITS-1:0] REG_GAIN_FIRST  = 3'd0;
   localparam logic [REG_BITS-1:0] REG_FB1_FIRST   = 3'd1;
   localparam logic [REG_BITS-1:0] REG_FB2_FIRST   = 3'd2;
   localparam logic [REG_BITS-1:0] REG_GAIN_SECOND = 3'd3;
   localparam logic [REG_BITS-1:0] REG_FB1_SECOND  = 3'd4;
   localparam logic [REG_BITS-1:0] REG_FB2_SECOND  = 3'd5;
   localparam logic [REG_BITS-1:0] REG_HIGHPASS    = 3'd6;

   // Control that travels with a product into the accumulator
   typedef struct packed {
      logic valid;
      logic first;
      logic shl;
      logic neg;
   } op_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/bbc_if.sv */
// Stream interfaces for the sample and result channels.
`default_nettype none

interface bbc_req_if import bbc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [IN_BITS-1:0] sample_in;
   logic                      start_of_trace;

   modport source (output valid, output sample_in, output start_of_trace, input ready);
   modport sink   (input valid, input sample_in, input start_of_trace, output ready);
endinterface

interface bbc_rsp_if import bbc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] sample_out;
   logic                       saturated;

   modport source (output valid, output sample_out, output saturated, input ready);
   modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

`default_nettype wire

/* hw/rtl/butterworth_biquad_cascade_core.sv */
// Two-section direct form I biquad cascade on one shared multiply-accumulate unit.
//
//   channel   dir  handshake        payload
//   req_chan  in   valid/ready      sample_in[23:0] signed, start_of_trace
//   rsp_chan  out  valid/ready      sample_out[23:0] signed, saturated
//   csr_*     in   APB write/read   7 registers at byte address 4*i, 32-bit data
//
// Each section runs 5 multiplies, 1 accumulate drain and 1 round/saturate step
// on the single multiplier, for both sections in turn. The next beat is taken
// only back in idle, so a sample is fully done before the next is accepted.
// reset is synchronous, active high; it clears coefficients and histories.
// A result waits in the output register; if it is still held when the next
// one is done, the sequencer waits until the output register frees up.
`default_nettype none

module butterworth_biquad_cascade_core import bbc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   bbc_req_if.sink                   req_chan,
   bbc_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [ADDR_BITS-1:0] csr_paddr,
   input  wire logic [DATA_BITS-1:0] csr_pwdata,
   output logic      [DATA_BITS-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAC   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam logic signed [WIDE_BITS-1:0] IN_MAX =
      WIDE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [WIDE_BITS-1:0] IN_MIN = ~IN_MAX;
   localparam logic signed [RND_BITS-1:0] RND_MAX =
      RND_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [RND_BITS-1:0] RND_MIN = ~RND_MAX;
   localparam logic signed [ACC_BITS-1:0] RND_HALF =
      ACC_BITS'(64'sd1 <<< (COEF_FRAC - 1));

   // Configuration registers
   logic signed [COEF_BITS-1:0] gain_ff [2];
   logic signed [COEF_BITS-1:0] fb1_ff  [2];
   logic signed [COEF_BITS-1:0] fb2_ff  [2];
   logic                        hp_ff;

   // Sequencer
   logic [2:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [SECT_BITS-1:0] sect_ff, sect_in;

   // Datapath
   logic signed [SAMPLE_BITS-1:0] cur_x_ff, cur_x_in;
   logic                          sat_ff, sat_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   op_ctl_type                    op_ff, op_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;

   logic signed [SAMPLE_BITS-1:0] x_hist_ff [SECTIONS][2];
   logic signed [SAMPLE_BITS-1:0] x_hist_in [SECTIONS][2];
   logic signed [SAMPLE_BITS-1:0] y_hist_ff [SECTIONS][2];
   logic signed [SAMPLE_BITS-1:0] y_hist_in [SECTIONS][2];

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_sat_ff, rsp_sat_in;

   logic                          req_fire;
   logic                          csr_write;
   logic [REG_BITS-1:0]           csr_index;
   logic signed [WIDE_BITS-1:0]   in_wide;
   logic signed [SAMPLE_BITS-1:0] in_clip;
   logic signed [COEF_BITS-1:0]   coef_sel;
   logic signed [SAMPLE_BITS-1:0] opnd_sel;
   logic signed [ACC_BITS-1:0]    term;
   logic signed [ACC_BITS-1:0]    rnd_sum;
   logic signed [RND_BITS-1:0]    rnd_val;
   logic signed [SAMPLE_BITS-1:0] y_val;
   logic                          y_clip;
   logic                          last_sect;
   logic                          rsp_free;
   logic                          load_rsp;

   // ---------------------------------------------------------------- CSR

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '{default: '0};
         fb1_ff  <= '{default: '0};
         fb2_ff  <= '{default: '0};
         hp_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_GAIN_FIRST:  gain_ff[0] <= csr_pwdata[COEF_BITS-1:0];
            REG_FB1_FIRST:   fb1_ff[0]  <= csr_pwdata[COEF_BITS-1:0];
            REG_FB2_FIRST:   fb2_ff[0]  <= csr_pwdata[COEF_BITS-1:0];
            REG_GAIN_SECOND: gain_ff[1] <= csr_pwdata[COEF_BITS-1:0];
            REG_FB1_SECOND:  fb1_ff[1]  <= csr_pwdata[COEF_BITS-1:0];
            REG_FB2_SECOND:  fb2_ff[1]  <= csr_pwdata[COEF_BITS-1:0];
            REG_HIGHPASS:    hp_ff      <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GAIN_FIRST:  csr_prdata = DATA_BITS'(gain_ff[0]);
         REG_FB1_FIRST:   csr_prdata = DATA_BITS'(fb1_ff[0]);
         REG_FB2_FIRST:   csr_prdata = DATA_BITS'(fb2_ff[0]);
         REG_GAIN_SECOND: csr_prdata = DATA_BITS'(gain_ff[1]);
         REG_FB1_SECOND:  csr_prdata = DATA_BITS'(fb1_ff[1]);
         REG_FB2_SECOND:  csr_prdata = DATA_BITS'(fb2_ff[1]);
         REG_HIGHPASS:    csr_prdata = {{(DATA_BITS-1){1'b0}}, hp_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- handshake

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign req_fire            = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = OUT_BITS'(rsp_sample_ff);
   assign rsp_chan.saturated  = rsp_sat_ff;

   // Input range clip for narrow sample widths; does not flag saturation
   always_comb begin
      in_wide = WIDE_BITS'(req_chan.sample_in);
      if (in_wide > IN_MAX) begin
         in_clip = SAMPLE_BITS'(IN_MAX);
      end else if (in_wide < IN_MIN) begin
         in_clip = SAMPLE_BITS'(IN_MIN);
      end else begin
         in_clip = SAMPLE_BITS'(in_wide);
      end
   end

   // ---------------------------------------------------- shared MAC unit

   always_comb begin
      coef_sel = gain_ff[sect_ff];
      opnd_sel = cur_x_ff;
      op_in    = '0;
      case (step_ff)
         OP_X0: begin
            opnd_sel = cur_x_ff;
         end
         OP_X1: begin
            opnd_sel  = x_hist_ff[sect_ff][0];
            op_in.shl = 1'b1;
            op_in.neg = hp_ff;
         end
         OP_X2: begin
            opnd_sel = x_hist_ff[sect_ff][1];
         end
         OP_Y1: begin
            coef_sel  = fb1_ff[sect_ff];
            opnd_sel  = y_hist_ff[sect_ff][0];
            op_in.neg = !hp_ff;
         end
         OP_Y2: begin
            coef_sel  = fb2_ff[sect_ff];
            opnd_sel  = y_hist_ff[sect_ff][1];
            op_in.neg = 1'b1;
         end
         default: ;
      endcase
      op_in.valid = (state_ff == ST_MAC);
      op_in.first = (step_ff == OP_X0);
      prod_in     = PROD_BITS'(coef_sel) * PROD_BITS'(opnd_sel);
   end

   always_comb begin
      term = op_ff.shl ? (ACC_BITS'(prod_ff) <<< 1) : ACC_BITS'(prod_ff);
      if (op_ff.valid) begin
         acc_in = (op_ff.first ? '0 : acc_ff) + (op_ff.neg ? -term : term);
      end else begin
         acc_in = acc_ff;
      end
   end

   // Round half up, then clip to the sample range
   always_comb begin
      rnd_sum = acc_ff + RND_HALF;
      rnd_val = RND_BITS'(rnd_sum >>> COEF_FRAC);
      y_clip  = (rnd_val > RND_MAX) || (rnd_val < RND_MIN);
      if (rnd_val > RND_MAX) begin
         y_val = SAMPLE_BITS'(RND_MAX);
      end else if (rnd_val < RND_MIN) begin
         y_val = SAMPLE_BITS'(RND_MIN);
      end else begin
         y_val = SAMPLE_BITS'(rnd_val);
      end
   end

   // ---------------------------------------------------------- sequencer

   assign last_sect = (sect_ff == SECT_BITS'(SECTIONS - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      sect_in       = sect_ff;
      cur_x_in      = cur_x_ff;
      sat_in        = sat_ff;
      x_hist_in     = x_hist_ff;
      y_hist_in     = y_hist_ff;
      load_rsp      = 1'b0;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MAC;
               step_in  = OP_X0;
               sect_in  = '0;
               cur_x_in = in_clip;
               sat_in   = 1'b0;
               if (req_chan.start_of_trace) begin
                  for (int s = 0; s < SECTIONS; s++) begin
                     x_hist_in[s] = '{default: '0};
                     y_hist_in[s] = '{default: '0};
                  end
               end
            end
         end
         ST_MAC: begin
            if (step_ff == OP_Y2) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            x_hist_in[sect_ff][1] = x_hist_ff[sect_ff][0];
            x_hist_in[sect_ff][0] = cur_x_ff;
            y_hist_in[sect_ff][1] = y_hist_ff[sect_ff][0];
            y_hist_in[sect_ff][0] = y_val;
            cur_x_in = y_val;
            sat_in   = sat_ff || y_clip;
            if (!last_sect) begin
               state_in = ST_MAC;
               step_in  = OP_X0;
               sect_in  = sect_ff + 1'b1;
            end else if (rsp_free) begin
               state_in      = ST_IDLE;
               load_rsp      = 1'b1;
               rsp_sample_in = y_val;
               rsp_sat_in    = sat_ff || y_clip;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               state_in      = ST_IDLE;
               load_rsp      = 1'b1;
               rsp_sample_in = cur_x_ff;
               rsp_sat_in    = sat_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= OP_X0;
         sect_ff      <= '0;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SECTIONS; s++) begin
            x_hist_ff[s] <= '{default: '0};
            y_hist_ff[s] <= '{default: '0};
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sect_ff      <= sect_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         x_hist_ff    <= x_hist_in;
         y_hist_ff    <= y_hist_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      sat_ff        <= sat_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   // ---------------------------------------------------------- assertions

   // an accepted beat always starts with the first section's first multiply
   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MAC && step_ff == OP_X0 && sect_ff == '0))
      else $error("sequence did not start at section zero");

   // start of trace leaves zero newest x and y histories for the first section
   a_trace_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.start_of_trace |=>
         (x_hist_ff[0][0] == '0 && y_hist_ff[0][0] == '0))
      else $error("histories not cleared on start of trace");

   // no product still in flight when the sum is rounded
   a_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> !op_ff.valid)
      else $error("rounding before accumulator drained");

   // a new result only comes out of the last section's round or the wait state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         ($past(state_ff) == ST_OUT || ($past(state_ff) == ST_ROUND && $past(last_sect))))
      else $error("result raised outside the final step");

endmodule

`default_nettype wire
